[rtl/block_statistics_unit_macros.svh]
// Assertion macros for the block statistics unit.
`ifndef BLOCK_STATISTICS_UNIT_MACROS_SVH
`define BLOCK_STATISTICS_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property, disabled while reset is asserted.
`define BSU_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked property, checked in every cycle, reset included.
`define BSU_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BSU_ASSERT_RST(label, clk, rst_n, prop, msg)

`define BSU_ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

[rtl/bstat_pkg.sv]
`default_nettype none

package bstat_pkg;

    localparam int DEF_MAX_COUNT = 1024;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 8;
    localparam int MEAN_OUT_W = 24;
    localparam int STD_OUT_W  = 24;
    localparam int CNT_OUT_W  = 11;
    localparam int STATUS_W   = 2;
    localparam int V_W        = 48;
    localparam int ROOT_W     = 24;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SINGLE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]   second_largest;
        logic                         has_second;
        logic signed [MEAN_OUT_W-1:0] mean_q8;
        logic [STD_OUT_W-1:0]         std_dev_q8;
        logic [CNT_OUT_W-1:0]         sample_count;
        logic [STATUS_W-1:0]          status;
    } t_out;

endpackage

`default_nettype wire

[rtl/block_statistics_unit.sv]
// Accumulation: one sample per cycle while a block is open, in_stall low.
// After the marked last sample the sequencer forms n*sumsq - sum^2 on the shared
// add/subtract unit, divides by n*(n-1), takes the root, divides the sum by n for the mean
// (mean only below two samples) and registers the result; no sample is taken meanwhile.
// i_rst_n is synchronous, active low: clears sums, count, extremes, flags and the output valid.
`default_nettype none

`include "block_statistics_unit_macros.svh"

module block_statistics_unit #(
    parameter int MAX_COUNT = bstat_pkg::DEF_MAX_COUNT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  bstat_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output bstat_pkg::t_out o_out
);

    localparam int LOG_W  = $clog2(MAX_COUNT);
    localparam int CNT_W  = $clog2(MAX_COUNT + 1);
    localparam int SUM_W  = bstat_pkg::SAMPLE_W + 1 + LOG_W;
    localparam int SQ_W   = 2 * bstat_pkg::SAMPLE_W - 1 + LOG_W;
    localparam int PROD_W = CNT_W + SQ_W;
    localparam int M_W    = 2 * CNT_W;
    localparam int MEAN_W = SUM_W + bstat_pkg::FRAC_W;
    localparam int DVD_W  = PROD_W + 2 * bstat_pkg::FRAC_W;
    localparam int MUL_W  = (SUM_W > CNT_W) ? SUM_W : CNT_W;
    localparam int STEP_W = $clog2(DVD_W + 1);
    localparam int SR_W   = bstat_pkg::ROOT_W + 2;
    localparam int V_W    = bstat_pkg::V_W;
    localparam int ROOT_W = bstat_pkg::ROOT_W;

    typedef enum logic [7:0] {
        S_ACC  = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_MULN = 8'b0000_0100,
        S_MULS = 8'b0000_1000,
        S_DIVV = 8'b0001_0000,
        S_SQRT = 8'b0010_0000,
        S_DIVM = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic signed [SUM_W-1:0]              r_sum, n_sum;
    logic [SQ_W-1:0]                      r_sumsq, n_sumsq;
    logic [CNT_W-1:0]                     r_count, n_count;
    logic signed [bstat_pkg::SAMPLE_W-1:0] r_largest, n_largest;
    logic signed [bstat_pkg::SAMPLE_W-1:0] r_second, n_second;
    logic                                 r_seen, n_seen;
    logic                                 r_overflowed, n_overflowed;

    logic [STEP_W-1:0] r_step, n_step;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [PROD_W-1:0] r_mcand, n_mcand;
    logic [MUL_W-1:0]  r_mplier, n_mplier;
    logic              r_sub, n_sub;
    logic [M_W-1:0]    r_m, n_m;
    logic [DVD_W-1:0]  r_dvd, n_dvd;
    logic [M_W-1:0]    r_rem, n_rem;
    logic [M_W-1:0]    r_dvs, n_dvs;
    logic [V_W-1:0]    r_sqv, n_sqv;
    logic [SR_W-1:0]   r_srem, n_srem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [ROOT_W-1:0] r_std, n_std;

    logic            r_out_valid, n_out_valid;
    bstat_pkg::t_out r_out, n_out;

    logic                                    in_acc;
    logic                                    last_step;
    logic                                    full;
    logic signed [bstat_pkg::SAMPLE_W-1:0]   x;
    logic signed [2*bstat_pkg::SAMPLE_W-1:0] sq;
    logic [SUM_W-1:0]                        mag;
    logic [PROD_W-1:0]                       mul_acc;
    logic [M_W:0]                            dv_t;
    logic [M_W:0]                            dv_diff;
    logic                                    dv_ge;
    logic [DVD_W-1:0]                        dv_dvd;
    logic [M_W-1:0]                          dv_rem;
    logic [SR_W+1:0]                         sq_t;
    logic [SR_W+1:0]                         sq_trial;
    logic [SR_W+1:0]                         sq_diff;
    logic                                    sq_ge;
    logic [ROOT_W-1:0]                       sq_root;
    logic [MEAN_W-1:0]                       mean_mag;
    logic [MEAN_W-1:0]                       mean_val;
    logic [CNT_W+bstat_pkg::CNT_OUT_W-1:0]   cnt_ext;
    logic [DVD_W-1:0]                        mean_dvd;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign last_step = (r_step == STEP_W'(1));
    assign full      = (r_count >= CNT_W'(MAX_COUNT));
    assign x         = i_in.sample;
    assign sq        = x * x;
    assign mag       = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    // shared add/subtract of the shift-add multiplier
    assign mul_acc = r_sub ? (r_acc - r_mcand) : (r_acc + r_mcand);

    // restoring divider step
    assign dv_t    = {r_rem, r_dvd[DVD_W-1]};
    assign dv_diff = dv_t - {1'b0, r_dvs};
    assign dv_ge   = (dv_t >= {1'b0, r_dvs});
    assign dv_dvd  = {r_dvd[DVD_W-2:0], dv_ge};
    assign dv_rem  = dv_ge ? dv_diff[M_W-1:0] : dv_t[M_W-1:0];

    // digit-by-digit root step, two radicand bits per cycle
    assign sq_t     = {r_srem, r_sqv[V_W-1 -: 2]};
    assign sq_trial = {(SR_W - ROOT_W)'(0), r_root, 2'b01};
    assign sq_diff  = sq_t - sq_trial;
    assign sq_ge    = (sq_t >= sq_trial);
    assign sq_root  = {r_root[ROOT_W-2:0], sq_ge};

    assign mean_dvd = {mag, bstat_pkg::FRAC_W'(0), (DVD_W - MEAN_W)'(0)};
    assign mean_mag = r_dvd[MEAN_W-1:0];
    assign mean_val = r_sum[SUM_W-1] ? (MEAN_W'(0) - mean_mag) : mean_mag;
    assign cnt_ext  = {bstat_pkg::CNT_OUT_W'(0), r_count};

    always_comb begin
        n_state      = r_state;
        n_sum        = r_sum;
        n_sumsq      = r_sumsq;
        n_count      = r_count;
        n_largest    = r_largest;
        n_second     = r_second;
        n_seen       = r_seen;
        n_overflowed = r_overflowed;
        n_step       = r_step;
        n_acc        = r_acc;
        n_mcand      = r_mcand;
        n_mplier     = r_mplier;
        n_sub        = r_sub;
        n_m          = r_m;
        n_dvd        = r_dvd;
        n_rem        = r_rem;
        n_dvs        = r_dvs;
        n_sqv        = r_sqv;
        n_srem       = r_srem;
        n_root       = r_root;
        n_std        = r_std;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;

        unique case (r_state)
            S_ACC: begin
                if (in_acc) begin
                    if (full) begin
                        n_overflowed = 1'b1;
                    end else begin
                        priority if (r_count == CNT_W'(0)) begin
                            n_largest = x;
                        end else if (x > r_largest) begin
                            n_second  = r_largest;
                            n_seen    = 1'b1;
                            n_largest = x;
                        end else if (x < r_largest && (!r_seen || x > r_second)) begin
                            n_second = x;
                            n_seen   = 1'b1;
                        end
                        n_sum   = r_sum + SUM_W'(x);
                        n_sumsq = r_sumsq + SQ_W'($unsigned(sq));
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_in.last) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                n_m = M_W'(r_count) * M_W'(r_count - CNT_W'(1));
                if (r_count < CNT_W'(2)) begin
                    n_std   = '0;
                    n_dvd   = mean_dvd;
                    n_rem   = '0;
                    n_dvs   = M_W'(r_count);
                    n_step  = STEP_W'(MEAN_W);
                    n_state = S_DIVM;
                end else begin
                    n_acc    = '0;
                    n_mcand  = PROD_W'(r_sumsq);
                    n_mplier = MUL_W'(r_count);
                    n_sub    = 1'b0;
                    n_step   = STEP_W'(CNT_W);
                    n_state  = S_MULN;
                end
            end
            S_MULN, S_MULS: begin
                if (r_mplier[0]) begin
                    n_acc = mul_acc;
                end
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_step   = r_step - STEP_W'(1);
                if (last_step) begin
                    if (r_state == S_MULN) begin
                        n_mcand  = PROD_W'(mag);
                        n_mplier = MUL_W'(mag);
                        n_sub    = 1'b1;
                        n_step   = STEP_W'(SUM_W);
                        n_state  = S_MULS;
                    end else begin
                        n_dvd   = {(r_mplier[0] ? mul_acc : r_acc),
                                   (2 * bstat_pkg::FRAC_W)'(0)};
                        n_rem   = '0;
                        n_dvs   = r_m;
                        n_step  = STEP_W'(DVD_W);
                        n_state = S_DIVV;
                    end
                end
            end
            S_DIVV: begin
                n_dvd  = dv_dvd;
                n_rem  = dv_rem;
                n_step = r_step - STEP_W'(1);
                if (last_step) begin
                    n_sqv   = dv_dvd[V_W-1:0];
                    n_srem  = '0;
                    n_root  = '0;
                    n_step  = STEP_W'(ROOT_W);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                n_sqv  = r_sqv << 2;
                n_srem = sq_ge ? sq_diff[SR_W-1:0] : sq_t[SR_W-1:0];
                n_root = sq_root;
                n_step = r_step - STEP_W'(1);
                if (last_step) begin
                    n_std   = sq_root;
                    n_dvd   = mean_dvd;
                    n_rem   = '0;
                    n_dvs   = M_W'(r_count);
                    n_step  = STEP_W'(MEAN_W);
                    n_state = S_DIVM;
                end
            end
            S_DIVM: begin
                n_dvd  = dv_dvd;
                n_rem  = dv_rem;
                n_step = r_step - STEP_W'(1);
                if (last_step) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.second_largest = r_second;
                    n_out.has_second     = r_seen;
                    n_out.mean_q8        = mean_val[bstat_pkg::MEAN_OUT_W-1:0];
                    n_out.std_dev_q8     = r_std;
                    n_out.sample_count   = cnt_ext[bstat_pkg::CNT_OUT_W-1:0];
                    if (r_overflowed) begin
                        n_out.status = bstat_pkg::ST_OVERFLOW;
                    end else if (r_count < CNT_W'(2)) begin
                        n_out.status = bstat_pkg::ST_SINGLE;
                    end else begin
                        n_out.status = bstat_pkg::ST_OK;
                    end
                    n_out_valid  = 1'b1;
                    n_sum        = '0;
                    n_sumsq      = '0;
                    n_count      = '0;
                    n_largest    = bstat_pkg::SAMPLE_MIN;
                    n_second     = bstat_pkg::SAMPLE_MIN;
                    n_seen       = 1'b0;
                    n_overflowed = 1'b0;
                    n_state      = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_ACC;
            r_sum        <= '0;
            r_sumsq      <= '0;
            r_count      <= '0;
            r_largest    <= bstat_pkg::SAMPLE_MIN;
            r_second     <= bstat_pkg::SAMPLE_MIN;
            r_seen       <= 1'b0;
            r_overflowed <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sum        <= n_sum;
            r_sumsq      <= n_sumsq;
            r_count      <= n_count;
            r_largest    <= n_largest;
            r_second     <= n_second;
            r_seen       <= n_seen;
            r_overflowed <= n_overflowed;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_sub    <= n_sub;
        r_m      <= n_m;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_sqv    <= n_sqv;
        r_srem   <= n_srem;
        r_root   <= n_root;
        r_std    <= n_std;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_ACC);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `BSU_ASSERT_RST(a_count_cap, i_clk, i_rst_n, r_count <= CNT_W'(MAX_COUNT), "count above limit")
    `BSU_ASSERT_RST(a_ovf_full, i_clk, i_rst_n, r_overflowed |-> full, "overflow before full")
    `BSU_ASSERT_RST(a_last_prep, i_clk, i_rst_n, (in_acc && i_in.last) |=> r_state == S_PREP, "last beat did not start the sequencer")
    `BSU_ASSERT_RST(a_rem_bound, i_clk, i_rst_n, (r_state == S_DIVV || r_state == S_DIVM) |-> r_rem < r_dvs, "divider remainder out of range")
    `BSU_ASSERT_RST(a_out_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_DONE), "result beat outside done state")
    `BSU_ASSERT_CLK(a_rst_out, i_clk, !i_rst_n |=> !r_out_valid, "result valid after reset")

endmodule

`default_nettype wire
